// ----- sv/uart_register_block_defines.svh -----
// Assertion macros for the port checker of the UART register block.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef UART_REGISTER_BLOCK_DEFINES_SVH
`define UART_REGISTER_BLOCK_DEFINES_SVH

// Checked at every clock edge outside of reset.
`define URB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, during reset too.
`define URB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/urb_pkg.sv -----
// Package of the UART register block: field widths, access codes, register
// offsets, reset values and the ID byte table. Depends on nothing.
`default_nettype none

package urb_pkg;

    localparam int OFFSET_W = 12;
    localparam int DATA_W   = 32;
    localparam int BYTE_W   = 8;

    localparam int IBRD_W  = 16;
    localparam int FBRD_W  = 6;
    localparam int LCRH_W  = 8;
    localparam int CTRL_W  = 16;
    localparam int IFLS_W  = 6;
    localparam int INT_W   = 11;
    localparam int DMACR_W = 3;

    typedef logic [OFFSET_W-1:0] t_offset;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_access_cmd;

    localparam t_offset OFS_DATA    = 12'h000;
    localparam t_offset OFS_FLAGS   = 12'h018;
    localparam t_offset OFS_IBRD    = 12'h024;
    localparam t_offset OFS_FBRD    = 12'h028;
    localparam t_offset OFS_LCRH    = 12'h02C;
    localparam t_offset OFS_CTRL    = 12'h030;
    localparam t_offset OFS_IFLS    = 12'h034;
    localparam t_offset OFS_IMSC    = 12'h038;
    localparam t_offset OFS_RIS     = 12'h03C;
    localparam t_offset OFS_MIS     = 12'h040;
    localparam t_offset OFS_ICR     = 12'h044;
    localparam t_offset OFS_DMACR   = 12'h048;
    localparam t_offset OFS_ID_BASE = 12'hFE0;

    localparam logic [CTRL_W-1:0] CTRL_RESET = 16'h0301;
    localparam int                CTRL_TXE_BIT = 8;
    localparam logic [IFLS_W-1:0] IFLS_RESET = 6'h12;
    localparam logic [INT_W-1:0]  RIS_RESET  = 11'h020;
    localparam logic [DATA_W-1:0] FLAGS_VALUE = 32'h0000_0090;

    function automatic logic [BYTE_W-1:0] id_byte(input logic [2:0] sel);
        logic [BYTE_W-1:0] v;
        unique case (sel)
            3'd0: v = 8'h11;
            3'd1: v = 8'h10;
            3'd2: v = 8'h34;
            3'd3: v = 8'h00;
            3'd4: v = 8'h0D;
            3'd5: v = 8'hF0;
            3'd6: v = 8'h05;
            3'd7: v = 8'hB1;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/urb_req_if.sv -----
// Request channel of the UART register block: one bus access per beat.
// Depends on urb_pkg for the field widths.
`default_nettype none

interface urb_req_if
    import urb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic                instance_req;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   wdata;

    modport source (output valid, cmd, instance_req, offset, wdata, input ready);
    modport sink   (input valid, cmd, instance_req, offset, wdata, output ready);
endinterface

`default_nettype wire

// ----- sv/urb_rsp_if.sv -----
// Response channel of the UART register block: one result per beat.
// Depends on urb_pkg for the field widths.
`default_nettype none

interface urb_rsp_if
    import urb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] rdata;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;

    modport source (output valid, rdata, tx_valid, tx_byte, input ready);
    modport sink   (input valid, rdata, tx_valid, tx_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/uart_register_block.sv -----
// Top level of the UART register block: register file for several UART instances.
// Depends on urb_pkg, urb_req_if and urb_rsp_if.
//
//   channel | direction | beat
//   i_req   | in        | cmd, instance_req, offset, wdata
//   o_rsp   | out       | rdata, tx_valid, tx_byte
//
// Each access passes through an input register,
// then decode and register update, then the result register.
// One access is accepted every cycle while the result side takes its beats.
// A stalled result holds in the result register; the input register then
// holds one more access and i_req.ready drops.
// Reset clears r_s1_valid and r_out_valid and sets each instance's UART registers to their reset values.
`default_nettype none

module uart_register_block
    import urb_pkg::*;
#(
    parameter int NUM_INSTANCES = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    urb_req_if.sink     i_req,
    urb_rsp_if.source   o_rsp
);

    localparam int IW = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;

    logic                r_s1_valid;
    logic                r_s1_cmd;
    logic                r_s1_inst;
    logic [OFFSET_W-1:0] r_s1_offset;
    logic [DATA_W-1:0]   r_s1_wdata;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_rdata;
    logic                r_tx_valid;
    logic [BYTE_W-1:0]   r_tx_byte;

    logic [IBRD_W-1:0]  r_ibrd  [NUM_INSTANCES];
    logic [FBRD_W-1:0]  r_fbrd  [NUM_INSTANCES];
    logic [LCRH_W-1:0]  r_lcrh  [NUM_INSTANCES];
    logic [CTRL_W-1:0]  r_ctrl  [NUM_INSTANCES];
    logic [IFLS_W-1:0]  r_ifls  [NUM_INSTANCES];
    logic [INT_W-1:0]   r_imsc  [NUM_INSTANCES];
    logic [INT_W-1:0]   r_ris   [NUM_INSTANCES];
    logic [DMACR_W-1:0] r_dmacr [NUM_INSTANCES];

    logic              s1_go;
    logic              in_range;
    logic [IW-1:0]     idx;
    logic              do_write;
    logic [DATA_W-1:0] n_rdata;
    logic              n_tx_valid;
    logic [BYTE_W-1:0] n_tx_byte;

    assign s1_go       = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_go;
    assign idx         = IW'(r_s1_inst);
    assign in_range    = (NUM_INSTANCES > 1) || (r_s1_inst == 1'b0);
    assign do_write    = s1_go && (r_s1_cmd == CMD_WRITE) && in_range;

    always_comb begin
        n_rdata    = '0;
        n_tx_valid = 1'b0;
        n_tx_byte  = '0;
        if (in_range && r_s1_cmd == CMD_READ) begin
            if (r_s1_offset >= OFS_ID_BASE && r_s1_offset[1:0] == 2'b00) begin
                n_rdata = DATA_W'(id_byte(r_s1_offset[4:2]));
            end else begin
                unique case (r_s1_offset)
                    OFS_FLAGS: n_rdata = FLAGS_VALUE;
                    OFS_IBRD:  n_rdata = DATA_W'(r_ibrd[idx]);
                    OFS_FBRD:  n_rdata = DATA_W'(r_fbrd[idx]);
                    OFS_LCRH:  n_rdata = DATA_W'(r_lcrh[idx]);
                    OFS_CTRL:  n_rdata = DATA_W'(r_ctrl[idx]);
                    OFS_IFLS:  n_rdata = DATA_W'(r_ifls[idx]);
                    OFS_IMSC:  n_rdata = DATA_W'(r_imsc[idx]);
                    OFS_RIS:   n_rdata = DATA_W'(r_ris[idx]);
                    OFS_MIS:   n_rdata = DATA_W'(r_ris[idx] & r_imsc[idx]);
                    OFS_DMACR: n_rdata = DATA_W'(r_dmacr[idx]);
                    default:   n_rdata = '0;
                endcase
            end
        end
        if (in_range && r_s1_cmd == CMD_WRITE && r_s1_offset == OFS_DATA
                && r_ctrl[idx][CTRL_TXE_BIT]) begin
            n_tx_valid = 1'b1;
            n_tx_byte  = r_s1_wdata[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1_cmd    <= i_req.cmd;
            r_s1_inst   <= i_req.instance_req;
            r_s1_offset <= i_req.offset;
            r_s1_wdata  <= i_req.wdata;
        end
        if (s1_go) begin
            r_rdata    <= n_rdata;
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_INSTANCES; i++) begin
                r_ibrd[i]  <= '0;
                r_fbrd[i]  <= '0;
                r_lcrh[i]  <= '0;
                r_ctrl[i]  <= CTRL_RESET;
                r_ifls[i]  <= IFLS_RESET;
                r_imsc[i]  <= '0;
                r_ris[i]   <= RIS_RESET;
                r_dmacr[i] <= '0;
            end
        end else if (do_write) begin
            unique case (r_s1_offset)
                OFS_IBRD:  r_ibrd[idx]  <= r_s1_wdata[IBRD_W-1:0];
                OFS_FBRD:  r_fbrd[idx]  <= r_s1_wdata[FBRD_W-1:0];
                OFS_LCRH:  r_lcrh[idx]  <= r_s1_wdata[LCRH_W-1:0];
                OFS_CTRL:  r_ctrl[idx]  <= r_s1_wdata[CTRL_W-1:0];
                OFS_IFLS:  r_ifls[idx]  <= r_s1_wdata[IFLS_W-1:0];
                OFS_IMSC:  r_imsc[idx]  <= r_s1_wdata[INT_W-1:0];
                OFS_ICR:   r_ris[idx]   <= r_ris[idx] & ~r_s1_wdata[INT_W-1:0];
                OFS_DMACR: r_dmacr[idx] <= r_s1_wdata[DMACR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.rdata    = r_rdata;
    assign o_rsp.tx_valid = r_tx_valid;
    assign o_rsp.tx_byte  = r_tx_byte;

endmodule

`default_nettype wire

// ----- sv/urb_checker.sv -----
// Port checker of the UART register block and its bind to the top level.
// Depends on urb_pkg and uart_register_block_defines.svh.
`default_nettype none

`include "uart_register_block_defines.svh"

module urb_checker
    import urb_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [DATA_W-1:0] i_rdata,
    input wire              i_tx_valid,
    input wire [BYTE_W-1:0] i_tx_byte
);

    `URB_ASSERT(a_no_beat_after_reset, !$past(i_rst_n) |-> !i_out_valid, "result beat right after reset")
    `URB_ASSERT(a_tx_has_no_rdata, (i_out_valid && i_tx_valid) |-> (i_rdata == '0), "transmit beat carries read data")
    `URB_ASSERT(a_idle_tx_byte_zero, (i_out_valid && !i_tx_valid) |-> (i_tx_byte == '0), "transmit byte without transmit")
    `URB_ASSERT(a_stall_holds, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_rdata)), "stalled result changed")

endmodule

bind uart_register_block urb_checker u_urb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_rdata     (o_rsp.rdata),
    .i_tx_valid  (o_rsp.tx_valid),
    .i_tx_byte   (o_rsp.tx_byte)
);

`default_nettype wire
